/* rtl/core/scsa_pkg.sv */
// Package of shared types, codes and size-class tables for the slab allocator core.
package scsa_pkg;

  // Fixed allocator geometry.
  localparam int unsigned ARENA_BYTES        = 4096;
  localparam int unsigned ARENA_HEADER_BYTES = 32;
  localparam int unsigned ALIGN_BYTES        = 8;
  localparam int unsigned BLOCK_HEADER_BYTES = 8;
  localparam int unsigned MAX_SMALL_BYTES    = 512;
  localparam int unsigned SIZE_CLASSES       = 31;
  localparam int unsigned MAX_BLOCKS         = 256;
  localparam int unsigned ARENA_NET          = ARENA_BYTES - ARENA_HEADER_BYTES;

  // Field and storage widths.
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned TOT_W   = 34;
  localparam int unsigned CLS_W   = 5;
  localparam int unsigned BLK_W   = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned BYTES_W = 10;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LNK_AW  = CLS_W + BLK_W;
  localparam int unsigned LNK_DEPTH = SIZE_CLASSES * MAX_BLOCKS;

  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [BLK_W-1:0]   blk_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [LNK_AW-1:0]  lnk_addr_t;

  // Result status codes.
  localparam stat_t ST_SMALL_OK  = 3'd0;
  localparam stat_t ST_ZERO_BLK  = 3'd1;
  localparam stat_t ST_LARGE_EXT = 3'd2;
  localparam stat_t ST_EXHAUSTED = 3'd3;
  localparam stat_t ST_FREED     = 3'd4;
  localparam stat_t ST_FREE_EXT  = 3'd5;
  localparam stat_t ST_ZERO_NOOP = 3'd6;
  localparam stat_t ST_NULL_NOOP = 3'd7;

  // Free handle kinds.
  localparam kind_t KIND_NULL  = 2'd0;
  localparam kind_t KIND_ZERO  = 2'd1;
  localparam kind_t KIND_LARGE = 2'd2;
  localparam kind_t KIND_SMALL = 2'd3;

  // Request type.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam bytes_t CLASS_BYTES [SIZE_CLASSES] = '{
    10'd16,  10'd24,  10'd32,  10'd40,  10'd48,  10'd56,  10'd64,  10'd72,
    10'd80,  10'd88,  10'd96,  10'd104, 10'd112, 10'd120, 10'd128,
    10'd144, 10'd160, 10'd176, 10'd192, 10'd208, 10'd224, 10'd240, 10'd256,
    10'd288, 10'd320, 10'd352, 10'd384, 10'd416, 10'd448, 10'd480, 10'd512
  };

  // Blocks per arena before the cap, worked out at elaboration.
  localparam int unsigned BLK_RAW [SIZE_CLASSES] = '{
    ARENA_NET / 16,  ARENA_NET / 24,  ARENA_NET / 32,  ARENA_NET / 40,
    ARENA_NET / 48,  ARENA_NET / 56,  ARENA_NET / 64,  ARENA_NET / 72,
    ARENA_NET / 80,  ARENA_NET / 88,  ARENA_NET / 96,  ARENA_NET / 104,
    ARENA_NET / 112, ARENA_NET / 120, ARENA_NET / 128,
    ARENA_NET / 144, ARENA_NET / 160, ARENA_NET / 176, ARENA_NET / 192,
    ARENA_NET / 208, ARENA_NET / 224, ARENA_NET / 240, ARENA_NET / 256,
    ARENA_NET / 288, ARENA_NET / 320, ARENA_NET / 352, ARENA_NET / 384,
    ARENA_NET / 416, ARENA_NET / 448, ARENA_NET / 480, ARENA_NET / 512
  };

  function automatic cnt_t class_blocks(cls_t c);
    int unsigned n;
    n = 0;
    if (int'(c) < SIZE_CLASSES) begin
      n = BLK_RAW[c];
    end
    if (n > MAX_BLOCKS) begin
      n = MAX_BLOCKS;
    end
    return cnt_t'(n);
  endfunction

  function automatic bytes_t class_bytes_of(cls_t c);
    bytes_t b;
    b = '0;
    if (int'(c) < SIZE_CLASSES) begin
      b = CLASS_BYTES[c];
    end
    return b;
  endfunction

  // Decoded allocation request.
  typedef struct packed {
    logic zero;
    logic oversize;
    cls_t cls;
  } dec_t;

  // One class table entry.
  typedef struct packed {
    cnt_t head;
    cnt_t used;
    cnt_t fresh;
  } entry_t;

  typedef struct packed {
    logic   re;
    cls_t   raddr;
    logic   we;
    cls_t   waddr;
    entry_t wdata;
  } cmem_req_t;

  typedef struct packed {
    logic      re;
    lnk_addr_t raddr;
    logic      we;
    lnk_addr_t waddr;
    cnt_t      wdata;
  } lmem_req_t;

endpackage

/* rtl/core/scsa_if.sv */
// Request and response channel interfaces of the slab allocator core.
interface scsa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] request_size;
  logic [1:0]  handle_kind;
  logic [4:0]  handle_class;
  logic [7:0]  handle_block;

  modport source (
    output valid, req_type, request_size, handle_kind, handle_class, handle_block,
    input  ready
  );
  modport sink (
    input  valid, req_type, request_size, handle_kind, handle_class, handle_block,
    output ready
  );
endinterface

interface scsa_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] size_class;
  logic [7:0] block_index;
  logic [9:0] block_bytes;
  logic       class_now_full;
  logic       class_now_empty;

  modport source (
    output valid, status, size_class, block_index, block_bytes, class_now_full,
           class_now_empty,
    input  ready
  );
  modport sink (
    input  valid, status, size_class, block_index, block_bytes, class_now_full,
           class_now_empty,
    output ready
  );
endinterface

/* rtl/core/size_class_slab_allocator_core.sv */
// Top level of the size-class slab allocator core.
//
//  Channel  Direction  Handshake             Carries
//  req_i    in         valid/ready           alloc or free request
//  rsp_o    out        valid/ready           one result per request
//  cfg      in         cfg_we_i, no stall    large_only bit
//
// The accept cycle reads the class table, the fetch state reads the link
// memory for an allocation, and the update state writes back the class table
// (and the link memory on a free) and loads the output register. Reset clears
// the class table valid bits at once, so no clearing pass is needed. A stalled
// result holds the block in its update step; a new request is taken once the
// previous one has left that step.
module size_class_slab_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  scsa_req_if.sink    req_i,
  scsa_rsp_if.source  rsp_o
);
  import scsa_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       large_only_q;

  // Request held for the duration of the transaction.
  logic   free_q;
  kind_t  kind_q;
  cls_t   cls_q;
  blk_t   blk_q;
  logic   zero_q;
  logic   large_q;
  entry_t ent_q;

  // Output register.
  logic   rsp_valid_q;
  stat_t  status_q;
  cls_t   size_class_q;
  blk_t   block_index_q;
  bytes_t block_bytes_q;
  logic   full_q;
  logic   empty_q;

  dec_t      dec;
  cls_t      sel_cls;
  logic      accept;
  logic      fire;
  cmem_req_t cmem;
  lmem_req_t lmem;
  entry_t    cls_rdata;
  cnt_t      link_rdata;

  // Result of the update step.
  stat_t  res_status;
  cls_t   res_cls;
  blk_t   res_blk;
  bytes_t res_bytes;
  logic   res_full;
  logic   res_empty;

  cnt_t   blk_count;
  bytes_t cls_bytes;
  logic   exhausted;
  logic   fresh_path;
  logic   bad_free;
  cnt_t   used_inc;
  cnt_t   used_dec;
  cnt_t   head_inc;

  scsa_decode u_decode (
    .request_size_i (req_i.request_size),
    .large_only_i   (large_only_q),
    .dec_o          (dec)
  );

  scsa_class_mem u_class_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cmem),
    .rdata_o (cls_rdata)
  );

  scsa_link_mem u_link_mem (
    .clk_i   (clk_i),
    .req_i   (lmem),
    .rdata_o (link_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign sel_cls     = (req_i.req_type == REQ_FREE) ? req_i.handle_class : dec.cls;
  assign fire        = (state_q == S_UPD) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_FETCH;
      S_FETCH: state_d = S_UPD;
      S_UPD:   if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The update step works from the registered class entry and link data.
  always_comb begin
    blk_count  = class_blocks(cls_q);
    cls_bytes  = class_bytes_of(cls_q);
    exhausted  = (ent_q.used >= blk_count) || (ent_q.head >= blk_count);
    fresh_path = (ent_q.head >= ent_q.fresh);
    bad_free   = (cls_q >= CLS_W'(SIZE_CLASSES)) || (CNT_W'(blk_q) >= blk_count)
                 || (ent_q.used == '0);
    used_inc   = ent_q.used + 1'b1;
    used_dec   = ent_q.used - 1'b1;
    head_inc   = ent_q.head + 1'b1;

    res_status = ST_NULL_NOOP;
    res_cls    = '0;
    res_blk    = '0;
    res_bytes  = '0;
    res_full   = 1'b0;
    res_empty  = 1'b0;

    cmem.re    = accept && (sel_cls < CLS_W'(SIZE_CLASSES));
    cmem.raddr = sel_cls;
    cmem.we    = 1'b0;
    cmem.waddr = cls_q;
    cmem.wdata = ent_q;

    // The link read is harmless when the head turns out to be fresh.
    lmem.re    = (state_q == S_FETCH) && (free_q == REQ_ALLOC);
    lmem.raddr = {cls_q, cls_rdata.head[BLK_W-1:0]};
    lmem.we    = 1'b0;
    lmem.waddr = {cls_q, blk_q};
    lmem.wdata = ent_q.head;

    if (free_q == REQ_ALLOC) begin
      priority if (zero_q) begin
        res_status = ST_ZERO_BLK;
      end else if (large_q) begin
        res_status = ST_LARGE_EXT;
      end else if (exhausted) begin
        res_status = ST_EXHAUSTED;
        res_cls    = cls_q;
        res_bytes  = cls_bytes;
      end else begin
        res_status = ST_SMALL_OK;
        res_cls    = cls_q;
        res_blk    = ent_q.head[BLK_W-1:0];
        res_bytes  = cls_bytes;
        res_full   = (used_inc == blk_count);
        cmem.we    = fire;
        cmem.wdata.used = used_inc;
        if (fresh_path) begin
          cmem.wdata.head  = head_inc;
          cmem.wdata.fresh = head_inc;
        end else begin
          cmem.wdata.head  = link_rdata;
        end
      end
    end else begin
      unique case (kind_q)
        KIND_NULL:  res_status = ST_NULL_NOOP;
        KIND_ZERO:  res_status = ST_ZERO_NOOP;
        KIND_LARGE: res_status = ST_FREE_EXT;
        KIND_SMALL: begin
          if (!bad_free) begin
            res_status = ST_FREED;
            res_cls    = cls_q;
            res_blk    = blk_q;
            res_bytes  = cls_bytes;
            res_empty  = (used_dec == '0);
            lmem.we    = fire;
            cmem.we    = fire;
            cmem.wdata.used = used_dec;
            // An emptied class goes back to the fresh sequential order.
            if (used_dec == '0) begin
              cmem.wdata.head  = '0;
              cmem.wdata.fresh = '0;
            end else begin
              cmem.wdata.head  = CNT_W'(blk_q);
            end
          end
        end
        default: res_status = ST_NULL_NOOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      large_only_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        large_only_q <= cfg_wdata_i;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      free_q  <= req_i.req_type;
      kind_q  <= req_i.handle_kind;
      cls_q   <= sel_cls;
      blk_q   <= req_i.handle_block;
      zero_q  <= dec.zero;
      large_q <= dec.oversize;
    end
    if (state_q == S_FETCH) begin
      ent_q <= cls_rdata;
    end
    if (fire) begin
      status_q      <= res_status;
      size_class_q  <= res_cls;
      block_index_q <= res_blk;
      block_bytes_q <= res_bytes;
      full_q        <= res_full;
      empty_q       <= res_empty;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.size_class      = size_class_q;
  assign rsp_o.block_index     = block_index_q;
  assign rsp_o.block_bytes     = block_bytes_q;
  assign rsp_o.class_now_full  = full_q;
  assign rsp_o.class_now_empty = empty_q;

endmodule

/* rtl/core/scsa_decode.sv */
// Size rounding and size-class decode for allocation requests.
module scsa_decode (
  input  logic [31:0]     request_size_i,
  input  logic            large_only_i,
  output scsa_pkg::dec_t  dec_o
);
  import scsa_pkg::*;

  logic [TOT_W-1:0]   sum;
  logic [TOT_W-1:0]   total;
  logic [BYTES_W:0]   t;
  logic [BYTES_W:0]   q8;
  logic [BYTES_W:0]   q16;
  logic [BYTES_W:0]   q32;
  logic [CLS_W:0]     cls_raw;

  always_comb begin
    sum   = TOT_W'(request_size_i) + TOT_W'(ALIGN_BYTES - 1);
    total = (sum & ~TOT_W'(ALIGN_BYTES - 1)) + TOT_W'(BLOCK_HEADER_BYTES);
    t     = total[BYTES_W:0];
    q8    = (t + 11'd7) >> 3;
    q16   = (t + 11'd15) >> 4;
    q32   = (t + 11'd31) >> 5;
    if (t <= 11'd16) begin
      cls_raw = '0;
    end else if (t <= 11'd128) begin
      cls_raw = (CLS_W+1)'(q8 - 11'd2);
    end else if (t <= 11'd256) begin
      cls_raw = (CLS_W+1)'(q16 + 11'd6);
    end else begin
      cls_raw = (CLS_W+1)'(q32 + 11'd14);
    end
    dec_o.zero     = (request_size_i == '0);
    dec_o.oversize = large_only_i || (total > TOT_W'(MAX_SMALL_BYTES));
    if (cls_raw >= (CLS_W+1)'(SIZE_CLASSES)) begin
      dec_o.cls = CLS_W'(SIZE_CLASSES - 1);
    end else begin
      dec_o.cls = cls_raw[CLS_W-1:0];
    end
  end

endmodule

/* rtl/core/scsa_class_mem.sv */
// Per-class state table with valid bits so that unwritten entries read as zero.
module scsa_class_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scsa_pkg::cmem_req_t  req_i,
  output scsa_pkg::entry_t     rdata_o
);
  import scsa_pkg::*;

  entry_t                  mem [SIZE_CLASSES];
  logic [SIZE_CLASSES-1:0] vld_q;
  entry_t                  rdata_q;
  logic                    rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* rtl/core/scsa_link_mem.sv */
// Free-list link memory, one entry per block of every class arena.
module scsa_link_mem (
  input  logic                 clk_i,
  input  scsa_pkg::lmem_req_t  req_i,
  output scsa_pkg::cnt_t       rdata_o
);
  import scsa_pkg::*;

  cnt_t mem [LNK_DEPTH];
  cnt_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
